// ----- rtl/pse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character constants and classifiers for the format-specifier extractor.
package pse_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChStar    = 8'h2A;  // '*'
  localparam logic [7:0] ChDot     = 8'h2E;  // '.'
  localparam logic [7:0] ChLowerD  = 8'h64;  // 'd', conversion of star tokens

  localparam logic [2:0] ModNone = 3'd0;

  localparam logic KindToken  = 1'b0;
  localparam logic KindStatus = 1'b1;

  // One queue entry: everything one request produces (token and/or status).
  typedef struct packed {
    logic       has_tok;
    logic [2:0] mod_first;
    logic [2:0] mod_second;
    logic [7:0] conv_char;
    logic       has_stat;
    logic       stat_ok;
  } entry_t;

  function automatic logic is_flag(input logic [7:0] c);
    is_flag = (c == 8'h2D) || (c == 8'h2B) || (c == 8'h20) || (c == 8'h23) || (c == 8'h30);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Valid conversion letters: d i o u x X e E f F g G a A c s p
  function automatic logic is_conv(input logic [7:0] c);
    is_conv = (c == 8'h64) || (c == 8'h69) || (c == 8'h6F) || (c == 8'h75) ||
              (c == 8'h78) || (c == 8'h58) || (c == 8'h65) || (c == 8'h45) ||
              (c == 8'h66) || (c == 8'h46) || (c == 8'h67) || (c == 8'h47) ||
              (c == 8'h61) || (c == 8'h41) || (c == 8'h63) || (c == 8'h73) ||
              (c == 8'h70);
  endfunction

  // Length modifier code: 1 h, 2 l, 3 j, 4 z, 5 t, 6 L, 0 otherwise.
  function automatic logic [2:0] mod_code(input logic [7:0] c);
    case (c)
      8'h68:   mod_code = 3'd1;
      8'h6C:   mod_code = 3'd2;
      8'h6A:   mod_code = 3'd3;
      8'h7A:   mod_code = 3'd4;
      8'h74:   mod_code = 3'd5;
      8'h4C:   mod_code = 3'd6;
      default: mod_code = ModNone;
    endcase
  endfunction

endpackage

// ----- rtl/pse_front.sv -----
`timescale 1ns / 1ps
// Front end: specifier parse state machine, one character per cycle while the queue is not full, builds queue entries.
module pse_front #(
  parameter int unsigned MOD_MAX = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      ch_i,
  input  logic            last_i,
  input  logic            q_full_i,
  output logic            push_o,
  output pse_pkg::entry_t entry_o
);

  localparam logic [2:0] PhText = 3'd0;
  localparam logic [2:0] PhPct  = 3'd1;
  localparam logic [2:0] PhFlag = 3'd2;
  localparam logic [2:0] PhWdig = 3'd3;
  localparam logic [2:0] PhWstr = 3'd4;
  localparam logic [2:0] PhDot  = 3'd5;
  localparam logic [2:0] PhPdig = 3'd6;
  localparam logic [2:0] PhLen  = 3'd7;

  localparam logic [1:0] ModMax = 2'(MOD_MAX);

  logic [2:0] phase_q, phase_d;
  logic [2:0] mod0_q, mod0_d, mod1_q, mod1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       failed_q, failed_d;

  logic       accept;
  logic       tok_v, star_tok;
  logic       use_len;
  logic [2:0] code;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign code       = pse_pkg::mod_code(ch_i);

  always_comb begin
    phase_d  = phase_q;
    mod0_d   = mod0_q;
    mod1_d   = mod1_q;
    cnt_d    = cnt_q;
    failed_d = failed_q;
    tok_v    = 1'b0;
    star_tok = 1'b0;
    use_len  = 1'b0;

    if (!failed_q) begin
      case (phase_q)
        PhText: begin
          if (ch_i == pse_pkg::ChPercent) begin
            phase_d = PhPct;
            mod0_d  = pse_pkg::ModNone;
            mod1_d  = pse_pkg::ModNone;
            cnt_d   = 2'd0;
          end
        end
        PhPct, PhFlag: begin
          if (phase_q == PhPct && ch_i == pse_pkg::ChPercent) begin
            phase_d = PhText;
          end else if (pse_pkg::is_flag(ch_i)) begin
            phase_d = PhFlag;
          end else if (ch_i == pse_pkg::ChStar) begin
            star_tok = 1'b1;
            phase_d  = PhWstr;
          end else if (pse_pkg::is_digit(ch_i)) begin
            phase_d = PhWdig;
          end else if (ch_i == pse_pkg::ChDot) begin
            phase_d = PhDot;
          end else begin
            use_len = 1'b1;
          end
        end
        PhWdig: begin
          if (pse_pkg::is_digit(ch_i)) begin
            phase_d = PhWdig;
          end else if (ch_i == pse_pkg::ChDot) begin
            phase_d = PhDot;
          end else begin
            use_len = 1'b1;
          end
        end
        PhWstr: begin
          if (ch_i == pse_pkg::ChDot) begin
            phase_d = PhDot;
          end else begin
            use_len = 1'b1;
          end
        end
        PhDot: begin
          if (ch_i == pse_pkg::ChStar) begin
            star_tok = 1'b1;
            phase_d  = PhLen;
          end else if (pse_pkg::is_digit(ch_i)) begin
            phase_d = PhPdig;
          end else begin
            use_len = 1'b1;
          end
        end
        PhPdig: begin
          if (pse_pkg::is_digit(ch_i)) begin
            phase_d = PhPdig;
          end else begin
            use_len = 1'b1;
          end
        end
        default: begin
          use_len = 1'b1;
        end
      endcase

      // length modifier / conversion letter stage
      if (use_len) begin
        if (code != pse_pkg::ModNone) begin
          if (cnt_q >= ModMax) begin
            failed_d = 1'b1;
          end else begin
            if (cnt_q == 2'd0) mod0_d = code;
            if (cnt_q == 2'd1) mod1_d = code;
            cnt_d   = cnt_q + 2'd1;
            phase_d = PhLen;
          end
        end else if (pse_pkg::is_conv(ch_i)) begin
          tok_v   = 1'b1;
          phase_d = PhText;
          mod0_d  = pse_pkg::ModNone;
          mod1_d  = pse_pkg::ModNone;
          cnt_d   = 2'd0;
        end else begin
          failed_d = 1'b1;
        end
        if (failed_d) begin
          phase_d = PhText;
          mod0_d  = pse_pkg::ModNone;
          mod1_d  = pse_pkg::ModNone;
          cnt_d   = 2'd0;
        end
      end
    end

    // end of string: unfinished specifier fails, then status
    if (last_i && phase_d != PhText) failed_d = 1'b1;

    entry_o.has_tok    = tok_v || star_tok;
    entry_o.mod_first  = star_tok ? pse_pkg::ModNone : mod0_q;
    entry_o.mod_second = star_tok ? pse_pkg::ModNone : mod1_q;
    entry_o.conv_char  = star_tok ? pse_pkg::ChLowerD : ch_i;
    entry_o.has_stat   = last_i;
    entry_o.stat_ok    = !failed_d;

    if (last_i) begin
      phase_d  = PhText;
      mod0_d   = pse_pkg::ModNone;
      mod1_d   = pse_pkg::ModNone;
      cnt_d    = 2'd0;
      failed_d = 1'b0;
    end
  end

  assign push_o = accept && (entry_o.has_tok || entry_o.has_stat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhText;
      mod0_q   <= pse_pkg::ModNone;
      mod1_q   <= pse_pkg::ModNone;
      cnt_q    <= 2'd0;
      failed_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      mod0_q   <= mod0_d;
      mod1_q   <= mod1_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ----- rtl/pse_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO of parse results between the front end and the output stage.
module pse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pse_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pse_pkg::entry_t head_o
);

  localparam int unsigned CntW = pse_pkg::QueuePtrW + 1;

  pse_pkg::entry_t                  slots_q [pse_pkg::QueueDepth];
  logic [pse_pkg::QueuePtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]                  cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(pse_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/pse_back.sv -----
`timescale 1ns / 1ps
// Back end: splits queue entries into token and status results, registered output.
module pse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pse_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     out_data_o,
  output logic            out_kind_o,
  output logic            out_last_o
);

  logic        valid_q, valid_d;
  logic        sub_q, sub_d;        // token of head already sent, status pending
  logic [15:0] data_q, data_d;
  logic        kind_q, kind_d;
  logic        last_q, last_d;
  logic        load, emit_tok;

  assign load     = !valid_q || out_ready_i;
  assign emit_tok = head_i.has_tok && !sub_q;

  always_comb begin
    valid_d = valid_q;
    sub_d   = sub_q;
    data_d  = data_q;
    kind_d  = kind_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (emit_tok) begin
          kind_d = pse_pkg::KindToken;
          data_d = {1'b0, 1'b0, head_i.conv_char, head_i.mod_second, head_i.mod_first};
          last_d = !head_i.has_stat;
          sub_d  = head_i.has_stat;
          pop_o  = !head_i.has_stat;
        end else begin
          kind_d = pse_pkg::KindStatus;
          data_d = {1'b0, head_i.stat_ok, 14'd0};
          last_d = 1'b1;
          sub_d  = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

endmodule

// ----- rtl/printf_spec_extractor.sv -----
`timescale 1ns / 1ps
// Top level of the printf format-specifier extractor.
//
// Usage: a format string enters on the s_axis side one byte per request, the
// final byte marked by s_axis_tlast_i. Each completed conversion specifier
// yields one token on m_axis (tuser = 0): modifier letter codes plus the
// conversion letter. A '*' width or precision yields an extra token with
// conversion 'd'. The final byte also yields a status result (tuser = 1)
// whose ok bit says whether the string was well formed.
// m_axis_tlast_o marks the last result caused by one input byte.
// Path: the parse and the queue write happen at the edge that accepts the byte,
// and the result then passes through the output register before it is presented.
// Throughput: one byte per cycle while the 4-entry queue has room; a byte that
// gives both a token and a status occupies the output register for both results in turn.
// The front parser stalls only when the queue is full, so a stalled receiver
// backs up the queue first and s_axis_tready_o falls once it fills.
// Reset: parser returns to plain text, modifiers and failure flag cleared,
// queue and output register emptied.
module printf_spec_extractor #(
  parameter int unsigned MOD_MAX = 2   // allowed length modifier letters, 1..3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // last byte of the string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] mod_first, [5:3] mod_second, [13:6] conv_char, [14] ok, [15] zero
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // kind: 0 token, 1 status
  output logic        m_axis_tlast_o    // run_end
);

  logic            q_full, q_empty, push, pop;
  pse_pkg::entry_t entry_in, head;

  // parser: classifies each byte and builds the request's results
  pse_front #(
    .MOD_MAX(MOD_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .ch_i       (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry_in)
  );

  // decouples the parser from output back-pressure
  pse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // expands entries into one or two results
  pse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
